### rtl/core/mlp_train_infer_engine_core_assert.svh
// Assertion macros for the perceptron engine core.
`ifndef MLP_TRAIN_INFER_ENGINE_CORE_ASSERT_SVH
`define MLP_TRAIN_INFER_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MLPTE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlpte core check failed");

// Next-cycle implication, checked outside reset
`define MLPTE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlpte core check failed");

`endif

### rtl/core/mlpte_pkg.sv
`timescale 1ns / 1ps

package mlpte_pkg;

  // Network shape and number format
  localparam int IN_NODES  = 64;
  localparam int HID_NODES = 16;
  localparam int OUT_NODES = 10;
  localparam int FRAC_BITS = 16;
  localparam int SIG_DEPTH = 256;

  localparam int HW_SIZE  = IN_NODES * HID_NODES;
  localparam int OW_SIZE  = HID_NODES * OUT_NODES;
  localparam int IN_AW    = $clog2(IN_NODES);
  localparam int HID_AW   = $clog2(HID_NODES);
  localparam int OUT_AW   = $clog2(OUT_NODES);
  localparam int HW_AW    = $clog2(HW_SIZE);
  localparam int OW_AW    = $clog2(OW_SIZE);
  localparam int SIG_AW   = $clog2(SIG_DEPTH);
  localparam int PIXCNT_W = $clog2(IN_NODES + 1);
  localparam int SIG_SHIFT = FRAC_BITS + 4 - SIG_AW;

  // Port field widths
  localparam int OP_W     = 2;
  localparam int PIX_W    = 8;
  localparam int DIGIT_W  = 4;
  localparam int EPOCH_W  = 16;
  localparam int WIDX_W   = 10;
  localparam int WORD_W   = 32;
  localparam int RATE_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DIV_CNT_W  = $clog2(RATE_W);

  // Request opcodes
  localparam logic [OP_W-1:0] OP_INFER  = 2'd0;
  localparam logic [OP_W-1:0] OP_TRAIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_WWRITE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOM_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE   = 2'd2;

  localparam logic [RATE_W-1:0] LR_RESET  = 17'd6554;
  localparam logic [RATE_W-1:0] MOM_RESET = 17'd58982;

  localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] SIG_OFFSET = 34'sd8 <<< FRAC_BITS;
  localparam logic signed [33:0] SIG_SPAN = 34'sd16 <<< FRAC_BITS;
  localparam logic [63:0] Q32_ONE = 64'd1 << 32;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HSUM, ST_HACT, ST_OSUM, ST_OEMIT, ST_DIV, ST_ODEL,
    ST_OSTEP, ST_OUPD, ST_HDSUM, ST_HDEL, ST_HSTEP, ST_HUPD
  } state_t;

  typedef logic signed [31:0] sig_tab_t [SIG_DEPTH];

  // Saturate a wide value to a 32-bit word
  function automatic logic signed [31:0] fx_sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Drop fraction bits of a full product, floor, then saturate
  function automatic logic signed [31:0] fx_fmul(input logic signed [65:0] p);
    return fx_sat32(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [63:0] fx_sat_add64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // Shift-subtract division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] r;
    logic signed [63:0] acc;
    if (a == '0) return Q32_ONE;
    y = a >> 4;
    term = Q32_ONE;
    acc = signed'(term);
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * y) >> 32, 64'(k));
      if ((k & 1) == 1) acc = acc - signed'(term);
      else acc = acc + signed'(term);
    end
    if (acc < 0) acc = '0;
    r = unsigned'(acc);
    if (r >= Q32_ONE) r = Q32_ONE - 64'd1;
    for (int k = 0; k < 4; k++) r = (r * r) >> 32;
    return r;
  endfunction

  function automatic logic signed [31:0] sig_entry(input int i);
    int num;
    logic [63:0] mag;
    logic [63:0] aq;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] n;
    num = 16 * i - 8 * SIG_DEPTH;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    aq = udiv64(mag << 32, 64'(SIG_DEPTH));
    e = exp_neg_q32(aq);
    den = Q32_ONE + e;
    n = (num < 0) ? (e << FRAC_BITS) : (64'd1 << (32 + FRAC_BITS));
    return 32'(udiv64(n + (den >> 1), den));
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t t;
    for (int i = 0; i < SIG_DEPTH; i++) t[i] = sig_entry(i);
    return t;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  // Sigmoid by table over [-8,8), clamped at both ends, or ReLU
  function automatic logic signed [31:0] fx_activate(input logic signed [31:0] net,
                                                     input logic relu);
    logic signed [33:0] u;
    logic [SIG_AW-1:0] idx;
    u = {{2{net[31]}}, net} + SIG_OFFSET;
    if (u < 0) idx = '0;
    else if (u >= SIG_SPAN) idx = SIG_AW'(SIG_DEPTH - 1);
    else idx = SIG_AW'(u >>> SIG_SHIFT);
    if (relu) return (net > 0) ? net : '0;
    return SIG_TAB[idx];
  endfunction

endpackage

### rtl/core/mlp_train_infer_engine_core.sv
`timescale 1ns / 1ps
`include "mlp_train_infer_engine_core_assert.svh"

// Two-layer perceptron (64 inputs, 16 hidden, 10 outputs) in Q16.16 with one
// shared 33x33 multiplier and a registered product, run by a phase sequencer.
// After reset the weight memories are cleared, one address a cycle, with busy
// high. A pixel or weight-write request leaves the block idle. The request
// with last_pixel set runs the forward pass, first the hidden layer and then
// the outputs; each multiply-accumulate is a memory read, a multiply and an
// add. A training request then runs the divider, the output deltas, the
// output weight updates, the hidden deltas and the hidden weight updates.
// One result per output node appears for exactly one cycle with out_valid;
// the receiver cannot stall it. busy stays high until all work of a request
// is done.
module mlp_train_infer_engine_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [mlpte_pkg::OP_W-1:0]            in_op,
  input  logic [mlpte_pkg::PIX_W-1:0]           in_pixel_value,
  input  logic                                  in_last_pixel,
  input  logic [mlpte_pkg::DIGIT_W-1:0]         in_target_digit,
  input  logic [mlpte_pkg::EPOCH_W-1:0]         in_epoch_count,
  input  logic                                  in_weight_layer,
  input  logic [mlpte_pkg::WIDX_W-1:0]          in_weight_index,
  input  logic signed [mlpte_pkg::WORD_W-1:0]   in_weight_value,
  output logic                                  out_valid,
  output logic [mlpte_pkg::DIGIT_W-1:0]         out_output_index,
  output logic signed [mlpte_pkg::WORD_W-1:0]   out_output_net,
  output logic signed [mlpte_pkg::WORD_W-1:0]   out_output_activation,
  output logic                                  out_last_output,
  input  logic                                  cfg_we,
  input  logic [mlpte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mlpte_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import mlpte_pkg::*;

  state_t state_r, state_nxt;
  logic [1:0]            ph_r;
  logic [1:0]            ph_last;
  logic                  ph_end;
  logic [IN_AW-1:0]      i_r;
  logic [HID_AW-1:0]     p_r;
  logic [OUT_AW-1:0]     q_r;
  logic [OW_AW-1:0]      k_r;
  logic [HW_AW-1:0]      clr_r;
  logic [PIXCNT_W-1:0]   pix_cnt_r;
  logic                  i_last, p_last, q_last;

  logic [RATE_W-1:0]     lr_r, mom_rate_r;
  logic                  relu_r;
  logic                  train_r;
  logic [DIGIT_W-1:0]    target_r;
  logic [EPOCH_W-1:0]    epoch_r;

  logic [RATE_W:0]       div_rem_r;
  logic [RATE_W-1:0]     div_quo_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [RATE_W-1:0]     div_d;
  logic [RATE_W:0]       div_sh;

  logic signed [63:0]    acc_r;
  logic signed [65:0]    prod_r;
  logic signed [31:0]    tmp_r, step_r, mom_r, w_r;
  logic signed [31:0]    hv_r   [HID_NODES];
  logic signed [31:0]    ov_r   [OUT_NODES];
  logic signed [31:0]    dout_r [OUT_NODES];
  logic signed [31:0]    dhid_r [HID_NODES];

  logic                  out_valid_r, out_last_r;
  logic [DIGIT_W-1:0]    out_idx_r;
  logic signed [31:0]    out_net_r, out_act_r;

  // Weight and pattern memories
  logic signed [31:0]    hw_mem  [HW_SIZE];
  logic signed [31:0]    hwp_mem [HW_SIZE];
  logic signed [31:0]    ow_mem  [OW_SIZE];
  logic signed [31:0]    owp_mem [OW_SIZE];
  logic [PIX_W-1:0]      pat_mem [IN_NODES];
  logic signed [31:0]    hw_q_r, hwp_q_r, ow_q_r, owp_q_r;
  logic [PIX_W-1:0]      pat_q_r;

  logic                  hw_we, ow_we, pat_we;
  logic [HW_AW-1:0]      hw_waddr, hw_raddr;
  logic [OW_AW-1:0]      ow_waddr;
  logic signed [31:0]    hw_wdata, hwp_wdata, ow_wdata, owp_wdata;

  logic                  accept, in_pix_op, in_ww, go;
  logic signed [32:0]    mul_a, mul_b;
  logic signed [31:0]    hv_sel, ov_sel, dout_sel, dhid_sel, der_src;
  logic signed [31:0]    tgt, err_o, err_h, one_minus, der_relu;
  logic signed [31:0]    diff_o, diff_h, upd_o, upd_h, act_in, act_out;
  logic signed [31:0]    net_o;

  assign accept    = start && !busy;
  assign in_pix_op = accept && (in_op == OP_INFER || in_op == OP_TRAIN);
  assign in_ww     = accept && (in_op == OP_WWRITE);
  assign go        = in_pix_op && in_last_pixel;

  assign i_last = (i_r == IN_AW'(IN_NODES - 1));
  assign p_last = (p_r == HID_AW'(HID_NODES - 1));
  assign q_last = (q_r == OUT_AW'(OUT_NODES - 1));

  // Last phase of each step
  always_comb begin
    case (state_r)
      ST_HSUM, ST_OSUM, ST_HDSUM:        ph_last = 2'd2;
      ST_ODEL, ST_OUPD, ST_HDEL, ST_HUPD: ph_last = 2'd3;
      ST_OSTEP, ST_HSTEP:                ph_last = 2'd1;
      default:                           ph_last = 2'd0;
    endcase
  end
  assign ph_end = (ph_r == ph_last);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == HW_AW'(HW_SIZE - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (go) state_nxt = ST_HSUM;
      ST_HSUM:  if (ph_end && i_last) state_nxt = ST_HACT;
      ST_HACT:  state_nxt = p_last ? ST_OSUM : ST_HSUM;
      ST_OSUM:  if (ph_end && p_last) state_nxt = ST_OEMIT;
      ST_OEMIT: if (q_last) state_nxt = train_r ? ST_DIV : ST_IDLE;
                else state_nxt = ST_OSUM;
      ST_DIV:   if (div_cnt_r == DIV_CNT_W'(RATE_W - 1)) state_nxt = ST_ODEL;
      ST_ODEL:  if (ph_end && q_last) state_nxt = ST_OSTEP;
      ST_OSTEP: if (ph_end) state_nxt = ST_OUPD;
      ST_OUPD:  if (ph_end && p_last) state_nxt = q_last ? ST_HDSUM : ST_OSTEP;
      ST_HDSUM: if (ph_end && q_last) state_nxt = ST_HDEL;
      ST_HDEL:  if (ph_end) state_nxt = p_last ? ST_HSTEP : ST_HDSUM;
      ST_HSTEP: if (ph_end) state_nxt = ST_HUPD;
      ST_HUPD:  if (ph_end && i_last) state_nxt = p_last ? ST_IDLE : ST_HSTEP;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Operand selection and update arithmetic
  always_comb begin
    hv_sel    = hv_r[p_r];
    ov_sel    = ov_r[q_r];
    dout_sel  = dout_r[q_r];
    dhid_sel  = dhid_r[p_r];
    der_src   = (state_r == ST_ODEL) ? ov_sel : hv_sel;
    tgt       = (4'(q_r) == target_r) ? FX_ONE : '0;
    err_o     = fx_sat32(66'(tgt) - 66'(ov_sel));
    err_h     = fx_sat32(66'(acc_r >>> FRAC_BITS));
    one_minus = fx_sat32(66'(FX_ONE) - 66'(der_src));
    der_relu  = (der_src > 0) ? FX_ONE : '0;
    diff_o    = fx_sat32(66'(ow_q_r) - 66'(owp_q_r));
    diff_h    = fx_sat32(66'(hw_q_r) - 66'(hwp_q_r));
    upd_o     = fx_sat32(66'(w_r) + 66'(fx_fmul(prod_r)) + 66'(mom_r));
    upd_h     = fx_sat32(66'(w_r) + prod_r + 66'(mom_r));
    net_o     = fx_sat32(66'(acc_r >>> FRAC_BITS));
    act_in    = (state_r == ST_HACT) ? fx_sat32(66'(acc_r)) : net_o;
    act_out   = fx_activate(act_in, relu_r);
    div_d     = {((epoch_r == '0) ? EPOCH_W'(1) : epoch_r), 1'b0};
    div_sh    = {div_rem_r[RATE_W-1:0], div_quo_r[RATE_W-1]};
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_HSUM: begin
        mul_a = {25'd0, pat_q_r};
        mul_b = 33'(hw_q_r);
      end
      ST_OSUM: begin
        mul_a = 33'(hv_sel);
        mul_b = 33'(ow_q_r);
      end
      ST_HDSUM: begin
        mul_a = 33'(dout_sel);
        mul_b = 33'(ow_q_r);
      end
      ST_ODEL, ST_HDEL: begin
        if (ph_r == 2'd0) begin
          mul_a = 33'(der_src);
          mul_b = 33'(one_minus);
        end else begin
          mul_a = 33'(tmp_r);
          mul_b = (state_r == ST_ODEL) ? 33'(err_o) : 33'(err_h);
        end
      end
      ST_OSTEP: begin
        mul_a = {16'd0, lr_r};
        mul_b = 33'(dout_sel);
      end
      ST_HSTEP: begin
        mul_a = {16'd0, lr_r};
        mul_b = 33'(dhid_sel);
      end
      ST_OUPD: begin
        if (ph_r == 2'd1) begin
          mul_a = {16'd0, div_quo_r};
          mul_b = 33'(diff_o);
        end else begin
          mul_a = 33'(step_r);
          mul_b = 33'(hv_sel);
        end
      end
      ST_HUPD: begin
        if (ph_r == 2'd1) begin
          mul_a = {16'd0, div_quo_r};
          mul_b = 33'(diff_h);
        end else begin
          mul_a = 33'(step_r);
          mul_b = {25'd0, pat_q_r};
        end
      end
      default: ;
    endcase
  end

  // Memory write ports
  always_comb begin
    hw_we     = 1'b0;
    hw_waddr  = clr_r;
    hw_wdata  = '0;
    hwp_wdata = '0;
    ow_we     = 1'b0;
    ow_waddr  = clr_r[OW_AW-1:0];
    ow_wdata  = '0;
    owp_wdata = '0;
    pat_we    = in_pix_op && (pix_cnt_r < PIXCNT_W'(IN_NODES));
    hw_raddr  = {i_r, p_r};
    unique case (state_r)
      ST_CLEAR: begin
        hw_we = 1'b1;
        ow_we = ({1'b0, clr_r} < (HW_AW + 1)'(OW_SIZE));
      end
      ST_IDLE: begin
        hw_waddr  = in_weight_index[HW_AW-1:0];
        hw_wdata  = in_weight_value;
        hwp_wdata = in_weight_value;
        ow_waddr  = in_weight_index[OW_AW-1:0];
        ow_wdata  = in_weight_value;
        owp_wdata = in_weight_value;
        hw_we = in_ww && !in_weight_layer &&
                ({1'b0, in_weight_index} < (WIDX_W + 1)'(HW_SIZE));
        ow_we = in_ww && in_weight_layer &&
                ({1'b0, in_weight_index} < (WIDX_W + 1)'(OW_SIZE));
      end
      ST_OUPD: begin
        ow_waddr  = k_r;
        ow_wdata  = upd_o;
        owp_wdata = w_r;
        ow_we     = (ph_r == 2'd3);
      end
      ST_HUPD: begin
        hw_waddr  = {i_r, p_r};
        hw_wdata  = upd_h;
        hwp_wdata = w_r;
        hw_we     = (ph_r == 2'd3);
      end
      default: ;
    endcase
  end

  // Memories with registered reads
  always_ff @(posedge clk) begin
    if (hw_we) begin
      hw_mem[hw_waddr]  <= hw_wdata;
      hwp_mem[hw_waddr] <= hwp_wdata;
    end
    if (ow_we) begin
      ow_mem[ow_waddr]  <= ow_wdata;
      owp_mem[ow_waddr] <= owp_wdata;
    end
    if (pat_we) begin
      pat_mem[pix_cnt_r[IN_AW-1:0]] <= in_pixel_value;
    end
    hw_q_r  <= hw_mem[hw_raddr];
    hwp_q_r <= hwp_mem[hw_raddr];
    ow_q_r  <= ow_mem[k_r];
    owp_q_r <= owp_mem[k_r];
    pat_q_r <= pat_mem[i_r];
  end

  // Sequencer, counters, configuration and node values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ph_r        <= '0;
      i_r         <= '0;
      p_r         <= '0;
      q_r         <= '0;
      k_r         <= '0;
      clr_r       <= '0;
      pix_cnt_r   <= '0;
      lr_r        <= LR_RESET;
      mom_rate_r  <= MOM_RESET;
      relu_r      <= 1'b0;
      train_r     <= 1'b0;
      target_r    <= '0;
      epoch_r     <= '0;
      div_rem_r   <= '0;
      div_quo_r   <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int n = 0; n < HID_NODES; n++) hv_r[n] <= '0;
      for (int n = 0; n < OUT_NODES; n++) ov_r[n] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_OEMIT);
      ph_r        <= ph_end ? 2'd0 : ph_r + 2'd1;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEARN_RATE: lr_r <= cfg_wdata;
          CFG_MOM_RATE:   mom_rate_r <= cfg_wdata;
          CFG_ACT_MODE:   relu_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          if (in_pix_op) begin
            if (in_last_pixel) begin
              pix_cnt_r <= '0;
              train_r   <= (in_op == OP_TRAIN);
              target_r  <= in_target_digit;
              epoch_r   <= in_epoch_count;
              i_r <= '0;
              p_r <= '0;
              q_r <= '0;
              k_r <= '0;
            end else if (pat_we) begin
              pix_cnt_r <= pix_cnt_r + 1'b1;
            end
          end
        end
        ST_HSUM: if (ph_end) i_r <= i_last ? '0 : i_r + 1'b1;
        ST_HACT: begin
          hv_r[p_r] <= act_out;
          p_r <= p_last ? '0 : p_r + 1'b1;
        end
        ST_OSUM: begin
          if (ph_end) begin
            if (p_last) p_r <= '0;
            else begin
              p_r <= p_r + 1'b1;
              k_r <= k_r + OW_AW'(OUT_NODES);
            end
          end
        end
        ST_OEMIT: begin
          ov_r[q_r]   <= act_out;
          q_r <= q_last ? '0 : q_r + 1'b1;
          k_r <= q_last ? '0 : OW_AW'(q_r) + OW_AW'(1);
          div_rem_r <= '0;
          div_quo_r <= mom_rate_r;
          div_cnt_r <= '0;
        end
        ST_DIV: begin
          // one quotient bit per cycle
          if (div_sh >= {1'b0, div_d}) begin
            div_rem_r <= div_sh - {1'b0, div_d};
            div_quo_r <= {div_quo_r[RATE_W-2:0], 1'b1};
          end else begin
            div_rem_r <= div_sh;
            div_quo_r <= {div_quo_r[RATE_W-2:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + 1'b1;
        end
        ST_ODEL: if (ph_end) q_r <= q_last ? '0 : q_r + 1'b1;
        ST_OUPD: begin
          if (ph_end) begin
            if (p_last) begin
              p_r <= '0;
              q_r <= q_last ? '0 : q_r + 1'b1;
              k_r <= q_last ? '0 : OW_AW'(q_r) + OW_AW'(1);
            end else begin
              p_r <= p_r + 1'b1;
              k_r <= k_r + OW_AW'(OUT_NODES);
            end
          end
        end
        ST_HDSUM: begin
          if (ph_end) begin
            q_r <= q_last ? '0 : q_r + 1'b1;
            k_r <= k_r + 1'b1;
          end
        end
        ST_HDEL: if (ph_end) p_r <= p_last ? '0 : p_r + 1'b1;
        ST_HUPD: begin
          if (ph_end) begin
            i_r <= i_last ? '0 : i_r + 1'b1;
            if (i_last) p_r <= p_last ? '0 : p_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: if (go) acc_r <= '0;
      ST_HSUM: if (ph_r == 2'd2) acc_r <= acc_r + prod_r[63:0];
      ST_HACT: acc_r <= '0;
      ST_OSUM, ST_HDSUM: begin
        if (ph_r == 2'd2) acc_r <= fx_sat_add64(acc_r, prod_r[63:0]);
      end
      ST_OEMIT: begin
        out_idx_r  <= 4'(q_r);
        out_net_r  <= net_o;
        out_act_r  <= act_out;
        out_last_r <= q_last;
        acc_r      <= '0;
      end
      ST_ODEL, ST_HDEL: begin
        if (ph_r == 2'd1) tmp_r <= relu_r ? der_relu : fx_fmul(prod_r);
        if (ph_r == 2'd3) begin
          if (state_r == ST_ODEL) dout_r[q_r] <= fx_fmul(prod_r);
          else begin
            dhid_r[p_r] <= fx_fmul(prod_r);
            acc_r       <= '0;
          end
        end
      end
      ST_OSTEP, ST_HSTEP: if (ph_r == 2'd1) step_r <= fx_fmul(prod_r);
      ST_OUPD: begin
        if (ph_r == 2'd1) w_r <= ow_q_r;
        if (ph_r == 2'd2) mom_r <= fx_fmul(prod_r);
      end
      ST_HUPD: begin
        if (ph_r == 2'd1) w_r <= hw_q_r;
        if (ph_r == 2'd2) mom_r <= fx_fmul(prod_r);
      end
      default: ;
    endcase
  end

  assign busy                  = (state_r != ST_IDLE);
  assign out_valid             = out_valid_r;
  assign out_output_index      = out_idx_r;
  assign out_output_net        = out_net_r;
  assign out_output_activation = out_act_r;
  assign out_last_output       = out_last_r;

  // Checks
  `MLPTE_ASSERT_NXT(a_strobe_single, out_valid_r, !out_valid_r)
  `MLPTE_ASSERT_NXT(a_last_pixel_starts, go, state_r == ST_HSUM)
  `MLPTE_ASSERT_IMP(a_mid_result_sums, out_valid_r && !out_last_r, state_r == ST_OSUM)
  `MLPTE_ASSERT_IMP(a_clear_quiet, state_r == ST_CLEAR, !out_valid_r && pix_cnt_r == '0)

endmodule

### tb/mlpte_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register ports, predicts each result of
// the perceptron engine and compares it field by field.
module mlpte_checker
  import mlpte_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [OP_W-1:0]           in_op,
  input  logic [PIX_W-1:0]          in_pixel_value,
  input  logic                      in_last_pixel,
  input  logic [DIGIT_W-1:0]        in_target_digit,
  input  logic [EPOCH_W-1:0]        in_epoch_count,
  input  logic                      in_weight_layer,
  input  logic [WIDX_W-1:0]         in_weight_index,
  input  logic signed [WORD_W-1:0]  in_weight_value,
  input  logic                      out_valid,
  input  logic [DIGIT_W-1:0]        out_output_index,
  input  logic signed [WORD_W-1:0]  out_output_net,
  input  logic signed [WORD_W-1:0]  out_output_activation,
  input  logic                      out_last_output,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  output int                        errors,
  output int                        pending_count
);

  typedef struct {
    logic [DIGIT_W-1:0] node;
    logic signed [31:0] net;
    logic signed [31:0] act;
    logic               last;
  } node_result_t;

  node_result_t node_results_due[$];

  logic [RATE_W-1:0] lrate;
  logic [RATE_W-1:0] mrate;
  logic              relu_mode;

  logic signed [31:0] w_hid [HW_SIZE];
  logic signed [31:0] w_hid_old [HW_SIZE];
  logic signed [31:0] w_out [OW_SIZE];
  logic signed [31:0] w_out_old [OW_SIZE];
  logic signed [31:0] hid_val [HID_NODES];
  logic signed [31:0] out_val [OUT_NODES];
  logic [7:0]         pixels [IN_NODES];
  int                 pix_pos;
  logic signed [31:0] sig_lut [SIG_DEPTH];

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> FRAC_BITS);
  endfunction

  function automatic longint acc_add(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // e^-a, both in Q32, by a truncated series on a/16 squared four times
  function automatic logic [63:0] decay_q32(input logic [63:0] a);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] r;
    longint s;
    if (a == 0) return 64'd1 << 32;
    y = a >> 4;
    term = 64'd1 << 32;
    s = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      if (k % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    r = s;
    if (r >= (64'd1 << 32)) r = (64'd1 << 32) - 1;
    for (int k = 0; k < 4; k++) r = (r * r) >> 32;
    return r;
  endfunction

  function automatic logic signed [31:0] squash(input logic signed [31:0] net);
    longint u;
    int lut_idx;
    if (relu_mode) return (net > 0) ? net : 32'sd0;
    u = longint'(net) + (longint'(8) << FRAC_BITS);
    if (u < 0) lut_idx = 0;
    else if (u >= (longint'(16) << FRAC_BITS)) lut_idx = SIG_DEPTH - 1;
    else lut_idx = int'((u * SIG_DEPTH) / (longint'(16) << FRAC_BITS));
    return sig_lut[lut_idx];
  endfunction

  function automatic logic signed [31:0] slope(input logic signed [31:0] v);
    if (relu_mode) return (v > 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
    return qmul(v, clamp32((longint'(1) << FRAC_BITS) - longint'(v)));
  endfunction

  // Build the sigmoid cells
  initial begin
    int num;
    logic [63:0] mag, aq, e, den, n;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      num = 16 * i - 8 * SIG_DEPTH;
      mag = (num < 0) ? 64'(-num) : 64'(num);
      aq = (mag << 32) / 64'(SIG_DEPTH);
      e = decay_q32(aq);
      den = (64'd1 << 32) + e;
      n = (num < 0) ? (e << FRAC_BITS) : (64'd1 << (32 + FRAC_BITS));
      sig_lut[i] = 32'((n + den / 2) / den);
    end
  end

  // Append one predicted result to the queue
  task automatic add_due(input node_result_t r);
    node_results_due.insert(node_results_due.size(), r);
  endtask

  task automatic clear_model();
    lrate = LR_RESET;
    mrate = MOM_RESET;
    relu_mode = 1'b0;
    for (int k = 0; k < HW_SIZE; k++) begin
      w_hid[k] = '0;
      w_hid_old[k] = '0;
    end
    for (int k = 0; k < OW_SIZE; k++) begin
      w_out[k] = '0;
      w_out_old[k] = '0;
    end
    foreach (hid_val[k]) hid_val[k] = '0;
    foreach (out_val[k]) out_val[k] = '0;
    foreach (pixels[k]) pixels[k] = '0;
    pix_pos = 0;
    node_results_due.delete();
  endtask

  // Backpropagation with momentum; output layer first
  task automatic backprop(input int target, input int epoch);
    logic signed [31:0] d_out [OUT_NODES];
    logic signed [31:0] d_hid [HID_NODES];
    logic signed [31:0] damp, lr, stp, w, mom;
    longint t, acc;
    int k;
    if (epoch == 0) epoch = 1;
    damp = int'(mrate) / (2 * epoch);
    lr = int'(lrate);
    for (int q = 0; q < OUT_NODES; q++) begin
      t = (q == target) ? (longint'(1) << FRAC_BITS) : 0;
      d_out[q] = qmul(slope(out_val[q]), clamp32(t - longint'(out_val[q])));
    end
    for (int q = 0; q < OUT_NODES; q++) begin
      stp = qmul(lr, d_out[q]);
      for (int p = 0; p < HID_NODES; p++) begin
        k = p * OUT_NODES + q;
        w = w_out[k];
        mom = qmul(damp, clamp32(longint'(w) - longint'(w_out_old[k])));
        w_out_old[k] = w;
        w_out[k] = clamp32(longint'(w) + longint'(qmul(stp, hid_val[p])) + longint'(mom));
      end
    end
    for (int p = 0; p < HID_NODES; p++) begin
      acc = 0;
      for (int q = 0; q < OUT_NODES; q++)
        acc = acc_add(acc, longint'(d_out[q]) * longint'(w_out[p * OUT_NODES + q]));
      d_hid[p] = qmul(slope(hid_val[p]), clamp32(acc >>> FRAC_BITS));
    end
    for (int p = 0; p < HID_NODES; p++) begin
      stp = qmul(lr, d_hid[p]);
      for (int i = 0; i < IN_NODES; i++) begin
        k = i * HID_NODES + p;
        w = w_hid[k];
        mom = qmul(damp, clamp32(longint'(w) - longint'(w_hid_old[k])));
        w_hid_old[k] = w;
        w_hid[k] = clamp32(longint'(w) + longint'(stp) * longint'(pixels[i]) + longint'(mom));
      end
    end
  endtask

  // Apply one accepted request and queue the node results it causes
  task automatic take_request();
    longint acc;
    logic signed [31:0] net;
    node_result_t r;
    if (in_op == OP_WWRITE) begin
      if (!in_weight_layer) begin
        if (in_weight_index < HW_SIZE) begin
          w_hid[in_weight_index] = in_weight_value;
          w_hid_old[in_weight_index] = in_weight_value;
        end
      end else if (in_weight_index < OW_SIZE) begin
        w_out[in_weight_index] = in_weight_value;
        w_out_old[in_weight_index] = in_weight_value;
      end
      return;
    end
    if (in_op != OP_INFER && in_op != OP_TRAIN) return;
    if (pix_pos < IN_NODES) begin
      pixels[pix_pos] = in_pixel_value;
      pix_pos++;
    end
    if (!in_last_pixel) return;
    pix_pos = 0;
    for (int p = 0; p < HID_NODES; p++) begin
      acc = 0;
      for (int i = 0; i < IN_NODES; i++)
        acc += longint'(pixels[i]) * longint'(w_hid[i * HID_NODES + p]);
      hid_val[p] = squash(clamp32(acc));
    end
    for (int q = 0; q < OUT_NODES; q++) begin
      acc = 0;
      for (int p = 0; p < HID_NODES; p++)
        acc = acc_add(acc, longint'(hid_val[p]) * longint'(w_out[p * OUT_NODES + q]));
      net = clamp32(acc >>> FRAC_BITS);
      out_val[q] = squash(net);
      r.node = DIGIT_W'(q);
      r.net = net;
      r.act = out_val[q];
      r.last = (q == OUT_NODES - 1);
      add_due(r);
    end
    if (in_op == OP_TRAIN) backprop(int'(in_target_digit), int'(in_epoch_count));
  endtask

  always @(posedge clk) begin
    node_result_t r;
    if (!rst_n) begin
      clear_model();
      errors = 0;
    end else begin
      // Compare a result against the oldest prediction
      if (out_valid) begin
        if (node_results_due.size() == 0) begin
          errors++;
          $display("%0t unexpected result: node %0d net %0d act %0d", $time,
                   out_output_index, out_output_net, out_output_activation);
        end else begin
          r = node_results_due.pop_front();
          if (out_output_index !== r.node) begin
            errors++;
            $display("%0t output_index: expected %0d actual %0d", $time, r.node,
                     out_output_index);
          end
          if (out_output_net !== r.net) begin
            errors++;
            $display("%0t output_net node %0d: expected %0d actual %0d", $time,
                     r.node, r.net, out_output_net);
          end
          if (out_output_activation !== r.act) begin
            errors++;
            $display("%0t output_activation node %0d: expected %0d actual %0d",
                     $time, r.node, r.act, out_output_activation);
          end
          if (out_last_output !== r.last) begin
            errors++;
            $display("%0t last_output node %0d: expected %0d actual %0d", $time,
                     r.node, r.last, out_last_output);
          end
        end
      end
      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEARN_RATE: lrate = cfg_wdata;
          CFG_MOM_RATE:   mrate = cfg_wdata;
          CFG_ACT_MODE:   relu_mode = cfg_wdata[0];
          default: ;
        endcase
      end
      if (start && !busy) take_request();
    end
    pending_count = node_results_due.size();
  end

  final begin
    if (node_results_due.size() != 0)
      $display("%0t %0d node results never arrived", $time, node_results_due.size());
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mlpte_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 60000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [OP_W-1:0] in_op;
  logic [PIX_W-1:0] in_pixel_value;
  logic in_last_pixel;
  logic [DIGIT_W-1:0] in_target_digit;
  logic [EPOCH_W-1:0] in_epoch_count;
  logic in_weight_layer;
  logic [WIDX_W-1:0] in_weight_index;
  logic signed [WORD_W-1:0] in_weight_value;
  logic out_valid;
  logic [DIGIT_W-1:0] out_output_index;
  logic signed [WORD_W-1:0] out_output_net;
  logic signed [WORD_W-1:0] out_output_activation;
  logic out_last_output;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int errors;
  int pending_count;
  int sender_idle_pct;
  int quiet_cycles;
  int items_sent;

  mlp_train_infer_engine_core dut (.*);
  mlpte_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive one request and hold it until accepted
  task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] pix,
                              input logic last, input logic [3:0] digit,
                              input logic [15:0] epoch, input logic layer,
                              input logic [9:0] widx, input logic [31:0] wval);
    @(negedge clk);
    start <= 1'b1;
    in_op <= op;
    in_pixel_value <= pix;
    in_last_pixel <= last;
    in_target_digit <= digit;
    in_epoch_count <= epoch;
    in_weight_layer <= layer;
    in_weight_index <= widx;
    in_weight_value <= wval;
    do @(posedge clk); while (busy);
    items_sent++;
    // Random gap after the request
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  function automatic logic [7:0] any_pixel();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pattern(input logic [OP_W-1:0] op, input int npix,
                              input logic [3:0] digit, input logic [15:0] epoch);
    for (int i = 0; i < npix; i++)
      send_request(op, any_pixel(), 1'b0, 4'($urandom), 16'($urandom), 1'($urandom),
                   10'($urandom), $urandom);
    send_request(op, any_pixel(), 1'b1, digit, epoch, 1'($urandom), 10'($urandom),
                 $urandom);
  endtask

  task automatic write_weight(input logic layer, input logic [9:0] widx,
                              input logic [31:0] wval);
    send_request(OP_WWRITE, 8'($urandom), 1'($urandom), 4'($urandom), 16'($urandom),
                 layer, widx, wval);
  endtask

  // Hold off until every result is in and the block is done
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int stop_at;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65)
        send_pattern($urandom_range(1) ? OP_TRAIN : OP_INFER, $urandom_range(5),
                     4'($urandom_range(15)), 16'($urandom));
      else if (pick < 90)
        write_weight(1'($urandom), 10'($urandom_range(1023)),
                     $urandom_range(7) == 0 ? $urandom :
                     32'($urandom_range(131072) - 65536));
      else if (pick < 95)
        send_request(OP_UNUSED, 8'($urandom), 1'($urandom), 4'($urandom),
                     16'($urandom), 1'($urandom), 10'($urandom), $urandom);
      else
        send_pattern(OP_TRAIN, 70, 4'($urandom_range(9)), 16'($urandom_range(1, 3)));
    end
  endtask

  // Stimulus
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_INFER;
    in_pixel_value = '0;
    in_last_pixel = 1'b0;
    in_target_digit = '0;
    in_epoch_count = 16'd1;
    in_weight_layer = 1'b0;
    in_weight_index = '0;
    in_weight_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_LEARN_RATE;
    cfg_wdata = '0;
    items_sent = 0;
    sender_idle_pct = 30;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ignored op, out-of-range writes, extreme weights, full pattern
    send_request(OP_UNUSED, 8'd255, 1'b1, 4'd3, 16'd5, 1'b0, 10'd0, 32'd0);
    write_weight(1'b1, 10'd160, 32'h7fffffff);
    write_weight(1'b1, 10'd1023, 32'h7fffffff);
    write_weight(1'b0, 10'd1023, 32'h0001_0000);
    write_weight(1'b0, 10'd0, 32'h0000_8000);
    write_weight(1'b1, 10'd0, 32'h0002_0000);
    write_weight(1'b1, 10'd159, 32'hfffe_0000);
    send_pattern(OP_TRAIN, 65, 4'd9, 16'd0);
    send_pattern(OP_TRAIN, 0, 4'd15, 16'd65535);
    send_pattern(OP_INFER, 2, 4'd0, 16'd1);
    write_weight(1'b0, 10'd17, 32'h7fffffff);
    write_weight(1'b1, 10'd11, 32'h80000000);
    send_pattern(OP_INFER, 0, 4'd10, 16'd1);
    send_pattern(OP_TRAIN, 1, 4'd0, 16'd1);
    random_phase(40);
    drain();

    // No learning, no momentum, sigmoid
    write_reg(CFG_LEARN_RATE, 17'd0);
    write_reg(CFG_MOM_RATE, 17'd0);
    write_reg(CFG_ACT_MODE, 17'd0);
    random_phase(50);
    drain();

    // Rates of one, ReLU; sender idles more
    sender_idle_pct = 74;
    write_reg(CFG_LEARN_RATE, 17'd65536);
    write_reg(CFG_MOM_RATE, 17'd65536);
    write_reg(CFG_ACT_MODE, 17'd1);
    write_weight(1'b1, 10'd5, 32'h0000_4000);
    send_pattern(OP_TRAIN, 3, 4'd5, 16'd1);
    random_phase(50);
    drain();

    // Random rates, back-to-back requests
    sender_idle_pct = 0;
    write_reg(CFG_LEARN_RATE, 17'($urandom_range(65536)));
    write_reg(CFG_MOM_RATE, 17'($urandom_range(65536)));
    write_reg(CFG_ACT_MODE, 17'd0);
    random_phase(45);
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: end the run after a long stretch with no traffic
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || !rst_n) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/mlpte_pkg.sv
rtl/core/mlp_train_infer_engine_core.sv
tb/mlpte_checker.sv
tb/testbench.sv
